/* src/ttcw_pkg.sv */
// shared types, constants and helpers for the text terminal character writer
`default_nettype none

package ttcw_pkg;

   // payload of one input transfer
   typedef struct packed {
      logic       kind;
      logic [7:0] char_code;
      logic [6:0] read_col;
      logic [5:0] read_row;
   } req_type;

   // payload of one result transfer
   typedef struct packed {
      logic [7:0]  cursor_col;
      logic [5:0]  cursor_row;
      logic [7:0]  cell_char;
      logic [15:0] cell_attr;
      logic        scrolled;
   } rsp_type;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTRIBUTE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INSERT_MODE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_DISPLAY = 3'd4;

   // register reset values
   localparam logic [7:0]  RST_COLUMNS   = 8'd80;
   localparam logic [6:0]  RST_ROWS      = 7'd25;
   localparam logic [15:0] RST_ATTRIBUTE = 16'd7;
   localparam logic        RST_INSERT    = 1'b0;
   localparam logic        RST_COLOR     = 1'b1;

   // cell layout: attribute in the upper bits, character in the low byte
   localparam int CELL_W = 24;

   // control bytes
   localparam logic [7:0] CHR_BS  = 8'h08;
   localparam logic [7:0] CHR_TAB = 8'h09;
   localparam logic [7:0] CHR_NL  = 8'h0A;
   localparam logic [7:0] CHR_CR  = 8'h0D;

   // monochrome box drawing substitution
   localparam logic [7:0] CHR_MONO_BELOW = 8'hAF;
   localparam logic [7:0] CHR_MONO_ABOVE = 8'hE0;
   localparam logic [7:0] CHR_VLINE_S    = 8'hB3;
   localparam logic [7:0] CHR_VLINE_D    = 8'hBA;
   localparam logic [7:0] CHR_HLINE_S    = 8'hC4;
   localparam logic [7:0] CHR_HLINE_D    = 8'hCD;
   localparam logic [7:0] CHR_SHADE_LO   = 8'hB0;
   localparam logic [7:0] CHR_SHADE_HI   = 8'hB2;
   localparam logic [7:0] CHR_PIPE       = 8'h7C;
   localparam logic [7:0] CHR_DASH       = 8'h2D;
   localparam logic [7:0] CHR_PLUS       = 8'h2B;
   localparam logic [7:0] CHR_SPACE      = 8'h20;

   // controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_READ_WAIT,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_FILL,
      ST_INS_RD,
      ST_INS_WR,
      ST_PUT
   } state_type;

   // store write source and address
   typedef enum logic [2:0] {
      WR_NONE,
      WR_ZERO,
      WR_BLANK,
      WR_SCROLL,
      WR_SHIFT,
      WR_CHAR
   } wr_sel_type;

   // store read address
   typedef enum logic [1:0] {
      RD_CELL,
      RD_SCROLL,
      RD_INSERT
   } rd_sel_type;

   // cursor update
   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_CR,
      CUR_TAB,
      CUR_BS,
      CUR_NL,
      CUR_ADV
   } cur_op_type;

   // sweep pointer update
   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_LAST_COL,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       rd_en;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      ptr_op_type ptr_op;
      cur_op_type cur_op;
      logic       rsp_load;
      logic       rsp_cell;
      logic       rsp_scrolled;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_read;
      logic is_cr;
      logic is_tab;
      logic is_bs;
      logic is_nl;
      logic col_ok;
      logic ins_needed;
      logic at_last_row;
      logic multi_row;
      logic scroll_last;
      logic fill_last;
      logic ins_last;
      logic clear_last;
   } dp_status_type;

   // box drawing codes to plain ascii for monochrome displays
   function automatic logic [7:0] mono_map(input logic [7:0] code);
      logic [7:0] res;
      res = code;
      if (code > CHR_MONO_BELOW && code < CHR_MONO_ABOVE) begin
         if (code == CHR_VLINE_S || code == CHR_VLINE_D) begin
            res = CHR_PIPE;
         end else if (code == CHR_HLINE_S || code == CHR_HLINE_D) begin
            res = CHR_DASH;
         end else if (code inside {[CHR_SHADE_LO:CHR_SHADE_HI]}) begin
            res = CHR_SPACE;
         end else begin
            res = CHR_PLUS;
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* src/text_terminal_char_writer.sv */
// Text terminal character writer top level: controller, datapath and assertions.
// Result strobe is registered from the result load made in decode for control bytes and plain writes,
// in read wait for cell reads, in put after a read and write per shifted cell for an insert, and
// at the end of the bottom row fill after a read and write per moved cell for a newline that scrolls.
// A new item is accepted in the cycle the strobe is shown; the receiver cannot stall.
// After reset busy stays high while every cell of the store is cleared.
`default_nettype none

module text_terminal_char_writer #(
   parameter int MAX_COLS  = 128,
   parameter int MAX_ROWS  = 64,
   parameter int TAB_WIDTH = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire ttcw_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   output ttcw_pkg::rsp_type                      rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ttcw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ttcw_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ttcw_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // configuration transfers are always taken
   assign csr_ready = 1'b1;

   ttcw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   ttcw_datapath #(
      .MAX_COLS  (MAX_COLS),
      .MAX_ROWS  (MAX_ROWS),
      .TAB_WIDTH (TAB_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // a result only appears once the controller is back to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // an accepted item always makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // one strobe per item, never two in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back to back result strobes");
`endif

endmodule

`default_nettype wire

/* src/ttcw_ram.sv */
// generic simple dual port ram with registered read
`default_nettype none

module ttcw_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* src/ttcw_ctrl.sv */
// controller state machine sequencing item decode, store sweeps and result strobes
`default_nettype none

module ttcw_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire ttcw_pkg::dp_status_type status,
   output ttcw_pkg::ctrl_cmd_type       cmd
);
   import ttcw_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register, store clear pass follows reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            if (status.is_read) begin
               state_in = ST_READ_WAIT;
            end else if (status.is_cr || status.is_tab || status.is_bs) begin
               state_in = ST_IDLE;
            end else if (status.is_nl) begin
               if (status.at_last_row) begin
                  state_in = status.multi_row ? ST_SCROLL_RD : ST_FILL;
               end
            end else if (status.col_ok && status.ins_needed) begin
               state_in = ST_INS_RD;
            end
         end
         ST_READ_WAIT: state_in = ST_IDLE;
         ST_SCROLL_RD: state_in = ST_SCROLL_WR;
         ST_SCROLL_WR: begin
            state_in = status.scroll_last ? ST_FILL : ST_SCROLL_RD;
         end
         ST_FILL: begin
            if (status.fill_last) state_in = ST_IDLE;
         end
         ST_INS_RD: state_in = ST_INS_WR;
         ST_INS_WR: begin
            state_in = status.ins_last ? ST_PUT : ST_INS_RD;
         end
         ST_PUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd.load_req     = 1'b0;
      cmd.rd_en        = 1'b0;
      cmd.rd_sel       = RD_CELL;
      cmd.wr_sel       = WR_NONE;
      cmd.ptr_op       = PTR_HOLD;
      cmd.cur_op       = CUR_HOLD;
      cmd.rsp_load     = 1'b0;
      cmd.rsp_cell     = 1'b0;
      cmd.rsp_scrolled = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.wr_sel = WR_ZERO;
            cmd.ptr_op = PTR_INC;
         end
         ST_IDLE: begin
            cmd.load_req = start;
         end
         ST_DECODE: begin
            if (status.is_read) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_CELL;
            end else if (status.is_cr) begin
               cmd.cur_op   = CUR_CR;
               cmd.rsp_load = 1'b1;
            end else if (status.is_tab) begin
               cmd.cur_op   = CUR_TAB;
               cmd.rsp_load = 1'b1;
            end else if (status.is_bs) begin
               cmd.cur_op   = CUR_BS;
               cmd.rsp_load = 1'b1;
            end else if (status.is_nl) begin
               if (status.at_last_row) begin
                  cmd.ptr_op = PTR_ZERO;
               end else begin
                  cmd.cur_op   = CUR_NL;
                  cmd.rsp_load = 1'b1;
               end
            end else if (!status.col_ok) begin
               // printable past the right edge is dropped
               cmd.rsp_load = 1'b1;
            end else if (status.ins_needed) begin
               cmd.ptr_op = PTR_LAST_COL;
            end else begin
               cmd.wr_sel   = WR_CHAR;
               cmd.cur_op   = CUR_ADV;
               cmd.rsp_load = 1'b1;
            end
         end
         ST_READ_WAIT: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_cell = 1'b1;
         end
         ST_SCROLL_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_SCROLL;
         end
         ST_SCROLL_WR: begin
            cmd.wr_sel = WR_SCROLL;
            cmd.ptr_op = PTR_INC;
         end
         ST_FILL: begin
            cmd.wr_sel = WR_BLANK;
            cmd.ptr_op = PTR_INC;
            if (status.fill_last) begin
               cmd.rsp_load     = 1'b1;
               cmd.rsp_scrolled = 1'b1;
            end
         end
         ST_INS_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_INSERT;
         end
         ST_INS_WR: begin
            cmd.wr_sel = WR_SHIFT;
            cmd.ptr_op = PTR_DEC;
         end
         ST_PUT: begin
            cmd.wr_sel   = WR_CHAR;
            cmd.cur_op   = CUR_ADV;
            cmd.rsp_load = 1'b1;
         end
         default: begin
            cmd.load_req = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* src/ttcw_datapath.sv */
// datapath: config registers, cursor, cell store, address generation and result register
`default_nettype none

module ttcw_datapath #(
   parameter int MAX_COLS  = 128,
   parameter int MAX_ROWS  = 64,
   parameter int TAB_WIDTH = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ttcw_pkg::ctrl_cmd_type                cmd,
   output ttcw_pkg::dp_status_type                    status,
   input  wire ttcw_pkg::req_type                     req_data,
   input  wire logic                                 csr_we,
   input  wire logic [ttcw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ttcw_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                      rsp_valid,
   output ttcw_pkg::rsp_type                          rsp_data
);
   import ttcw_pkg::*;

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int PW    = $clog2(TAB_WIDTH);

   typedef logic [AW-1:0] addr_type;
   typedef logic [AW:0]   addrx_type;
   typedef logic [RW-1:0] line_type;
   typedef logic [PW-1:0] phase_type;

   localparam addr_type  MC_A      = addr_type'(MAX_COLS);
   localparam addrx_type MC_X      = addrx_type'(MAX_COLS);
   localparam addr_type  LAST_ADDR = addr_type'(DEPTH - 1);
   localparam phase_type PH_LAST   = phase_type'(TAB_WIDTH - 1);
   localparam phase_type PH_SAT    = phase_type'(255 % TAB_WIDTH);

   // configuration registers
   logic [7:0]  columns_ff;
   logic [6:0]  rows_ff;
   logic [15:0] attr_ff;
   logic        insert_ff;
   logic        color_ff;

   // item and cursor state
   req_type   req_ff;
   logic [7:0] col_ff;
   logic [7:0] col_in;
   line_type  line_ff;
   line_type  line_in;
   phase_type phase_ff;
   phase_type phase_in;
   addr_type  ptr_ff;
   addr_type  ptr_in;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;

   // derived values
   logic [7:0]      nc;
   logic [7:0]      nc_m1;
   logic [6:0]      nr;
   logic [6:0]      nr_m1;
   line_type        line_clamp;
   logic [7:0]      rd_col;
   logic [6:0]      rd_row;
   addr_type        row_base;
   addr_type        cell_addr;
   addrx_type       lim_scroll;
   addrx_type       lim_fill;
   logic [8:0]      tab_next;
   logic [7:0]      put_char;

   // store ports
   logic            ram_wr_en;
   addr_type        ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data;
   addr_type        ram_rd_addr;
   logic [CELL_W-1:0] ram_rd_data;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= RST_COLUMNS;
         rows_ff    <= RST_ROWS;
         attr_ff    <= RST_ATTRIBUTE;
         insert_ff  <= RST_INSERT;
         color_ff   <= RST_COLOR;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COLUMNS:       columns_ff <= csr_wdata[7:0];
            CSR_ROWS:          rows_ff    <= csr_wdata[6:0];
            CSR_ATTRIBUTE:     attr_ff    <= csr_wdata;
            CSR_INSERT_MODE:   insert_ff  <= csr_wdata[0];
            CSR_COLOR_DISPLAY: color_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective geometry: zero counts as one, large values saturate
   always_comb begin
      if (columns_ff == 8'd0) begin
         nc = 8'd1;
      end else if ({1'b0, columns_ff} > 9'(MAX_COLS)) begin
         nc = 8'(MAX_COLS);
      end else begin
         nc = columns_ff;
      end
      if (rows_ff == 7'd0) begin
         nr = 7'd1;
      end else if ({1'b0, rows_ff} > 8'(MAX_ROWS)) begin
         nr = 7'(MAX_ROWS);
      end else begin
         nr = rows_ff;
      end
   end

   assign nc_m1 = nc - 8'd1;
   assign nr_m1 = nr - 7'd1;

   // write row, clamped when rows shrank under the cursor
   assign line_clamp = (7'(line_ff) > nr_m1) ? line_type'(nr_m1) : line_ff;
   assign row_base   = addr_type'(addr_type'(line_clamp) * MC_A);

   // read cell address with clamped coordinates
   assign rd_col    = ({1'b0, req_ff.read_col} > nc_m1) ? nc_m1 : {1'b0, req_ff.read_col};
   assign rd_row    = ({1'b0, req_ff.read_row} > nr_m1) ? nr_m1 : {1'b0, req_ff.read_row};
   assign cell_addr = addr_type'(addr_type'(rd_row) * MC_A) + addr_type'(rd_col);

   // sweep limits
   assign lim_scroll = addrx_type'(addrx_type'(nr_m1) * MC_X);
   assign lim_fill   = addrx_type'(addrx_type'(nr) * MC_X);

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   // status to controller
   always_comb begin
      status.is_read     = req_ff.kind;
      status.is_cr       = (req_ff.char_code == CHR_CR);
      status.is_tab      = (req_ff.char_code == CHR_TAB);
      status.is_bs       = (req_ff.char_code == CHR_BS);
      status.is_nl       = (req_ff.char_code == CHR_NL);
      status.col_ok      = (col_ff < nc);
      status.ins_needed  = insert_ff && (({1'b0, col_ff} + 9'd1) < {1'b0, nc});
      status.at_last_row = (7'(line_ff) >= nr_m1);
      status.multi_row   = (nr != 7'd1);
      status.scroll_last = ((addrx_type'(ptr_ff) + addrx_type'(1)) == lim_scroll);
      status.fill_last   = ((addrx_type'(ptr_ff) + addrx_type'(1)) == lim_fill);
      status.ins_last    = (addrx_type'(ptr_ff) == (addrx_type'(col_ff) + addrx_type'(1)));
      status.clear_last  = (ptr_ff == LAST_ADDR);
   end

   // sweep pointer
   always_comb begin
      ptr_in = ptr_ff;
      case (cmd.ptr_op)
         PTR_HOLD:     ptr_in = ptr_ff;
         PTR_ZERO:     ptr_in = '0;
         PTR_LAST_COL: ptr_in = addr_type'(nc_m1);
         PTR_INC:      ptr_in = ptr_ff + addr_type'(1);
         PTR_DEC:      ptr_in = ptr_ff - addr_type'(1);
         default:      ptr_in = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   // cursor update, tab phase tracks column modulo the tab width
   assign tab_next = {1'b0, col_ff} + 9'(TAB_WIDTH) - 9'(phase_ff);

   always_comb begin
      col_in   = col_ff;
      line_in  = line_ff;
      phase_in = phase_ff;
      case (cmd.cur_op)
         CUR_HOLD: col_in = col_ff;
         CUR_CR: begin
            col_in   = 8'd0;
            phase_in = '0;
         end
         CUR_TAB: begin
            if (col_ff < nc) begin
               if (tab_next > 9'd255) begin
                  col_in   = 8'hFF;
                  phase_in = PH_SAT;
               end else begin
                  col_in   = tab_next[7:0];
                  phase_in = '0;
               end
            end
         end
         CUR_BS: begin
            if (col_ff != 8'd0) begin
               col_in   = col_ff - 8'd1;
               phase_in = (phase_ff == '0) ? PH_LAST : phase_ff - phase_type'(1);
            end
         end
         CUR_NL: line_in = line_ff + line_type'(1);
         CUR_ADV: begin
            col_in   = col_ff + 8'd1;
            phase_in = (phase_ff == PH_LAST) ? '0 : phase_ff + phase_type'(1);
         end
         default: col_in = col_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= 8'd0;
         line_ff  <= '0;
         phase_ff <= '0;
      end else begin
         col_ff   <= col_in;
         line_ff  <= line_in;
         phase_ff <= phase_in;
      end
   end

   // character to store
   assign put_char = color_ff ? req_ff.char_code : mono_map(req_ff.char_code);

   // store write port
   always_comb begin
      ram_wr_en   = (cmd.wr_sel != WR_NONE);
      ram_wr_addr = ptr_ff;
      ram_wr_data = '0;
      case (cmd.wr_sel)
         WR_NONE: ram_wr_data = '0;
         WR_ZERO: ram_wr_data = '0;
         WR_BLANK: ram_wr_data = {16'h0000, CHR_SPACE};
         WR_SCROLL: ram_wr_data = ram_rd_data;
         WR_SHIFT: begin
            ram_wr_addr = row_base + ptr_ff;
            ram_wr_data = ram_rd_data;
         end
         WR_CHAR: begin
            ram_wr_addr = row_base + addr_type'(col_ff);
            ram_wr_data = {attr_ff, put_char};
         end
         default: ram_wr_data = '0;
      endcase
   end

   // store read port
   always_comb begin
      ram_rd_addr = cell_addr;
      case (cmd.rd_sel)
         RD_CELL:   ram_rd_addr = cell_addr;
         RD_SCROLL: ram_rd_addr = ptr_ff + MC_A;
         RD_INSERT: ram_rd_addr = row_base + ptr_ff - addr_type'(1);
         default:   ram_rd_addr = cell_addr;
      endcase
   end

   ttcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_cell_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // result register, cursor fields show the state after the item
   always_comb begin
      rsp_in.cursor_col = col_in;
      rsp_in.cursor_row = 6'(line_in);
      rsp_in.cell_char  = cmd.rsp_cell ? ram_rd_data[7:0] : 8'd0;
      rsp_in.cell_attr  = cmd.rsp_cell ? ram_rd_data[23:8] : 16'd0;
      rsp_in.scrolled   = cmd.rsp_scrolled;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* sim/tb.sv */
// self-checking testbench for the text terminal character writer
`default_nettype none

module tb;
   import ttcw_pkg::*;

   localparam int SCR_COLS = 128;
   localparam int SCR_ROWS = 64;
   localparam int TAB_STOP = 8;

   // tracks the screen contents and cursor, and checks each cursor report
   class terminal_screen;
      logic [23:0] glyphs [SCR_COLS*SCR_ROWS];
      int          col;
      int          line;
      int          width_reg;
      int          height_reg;
      logic [15:0] attr_reg;
      bit          insert_on;
      bit          color_on;
      rsp_type     cursor_reports [$];
      int          errors = 0;
      int          items = 0;
      int          reads = 0;
      int          scrolls = 0;
      int          inserts = 0;

      function void reset_state();
         foreach (glyphs[i]) glyphs[i] = '0;
         col = 0;
         line = 0;
         width_reg = int'(RST_COLUMNS);
         height_reg = int'(RST_ROWS);
         attr_reg = RST_ATTRIBUTE;
         insert_on = RST_INSERT;
         color_on = RST_COLOR;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_COLUMNS:       width_reg = int'(val[7:0]);
            CSR_ROWS:          height_reg = int'(val[6:0]);
            CSR_ATTRIBUTE:     attr_reg = val;
            CSR_INSERT_MODE:   insert_on = val[0];
            CSR_COLOR_DISPLAY: color_on = val[0];
            default: ;
         endcase
      endfunction

      function int cols_in_use();
         if (width_reg == 0) return 1;
         return (width_reg > SCR_COLS) ? SCR_COLS : width_reg;
      endfunction

      function int rows_in_use();
         if (height_reg == 0) return 1;
         return (height_reg > SCR_ROWS) ? SCR_ROWS : height_reg;
      endfunction

      function int outstanding();
         return cursor_reports.size();
      endfunction

      // box drawing codes shown on a monochrome display
      function logic [7:0] mono_glyph(logic [7:0] c);
         if (color_on || c <= CHR_MONO_BELOW || c >= CHR_MONO_ABOVE) return c;
         if (c == CHR_VLINE_S || c == CHR_VLINE_D) return CHR_PIPE;
         if (c == CHR_HLINE_S || c == CHR_HLINE_D) return CHR_DASH;
         if (c >= CHR_SHADE_LO && c <= CHR_SHADE_HI) return CHR_SPACE;
         return CHR_PLUS;
      endfunction

      // whole rows move up, bottom row becomes blanks of attribute zero
      function void scroll_up(int nr);
         for (int r = 0; r + 1 < nr; r++)
            for (int c = 0; c < SCR_COLS; c++)
               glyphs[r*SCR_COLS + c] = glyphs[(r+1)*SCR_COLS + c];
         for (int c = 0; c < SCR_COLS; c++)
            glyphs[(nr-1)*SCR_COLS + c] = {16'h0000, CHR_SPACE};
      endfunction

      // update the screen for one accepted item and queue its report
      function void apply_item(req_type it);
         rsp_type    r;
         int         nc;
         int         nr;
         int         x;
         int         y;
         int         base;
         int         nx;
         logic [7:0] code;
         nc = cols_in_use();
         nr = rows_in_use();
         r = '0;
         items++;
         if (it.kind) begin
            x = int'(it.read_col);
            y = int'(it.read_row);
            if (x > nc - 1) x = nc - 1;
            if (y > nr - 1) y = nr - 1;
            r.cell_char = glyphs[y*SCR_COLS + x][7:0];
            r.cell_attr = glyphs[y*SCR_COLS + x][23:8];
            reads++;
         end else begin
            case (it.char_code)
               CHR_CR: col = 0;
               CHR_TAB: begin
                  if (col < nc) begin
                     nx = col + TAB_STOP - col % TAB_STOP;
                     col = (nx > 255) ? 255 : nx;
                  end
               end
               CHR_BS: begin
                  if (col > 0) col--;
               end
               CHR_NL: begin
                  if (line >= nr - 1) begin
                     scroll_up(nr);
                     r.scrolled = 1'b1;
                     scrolls++;
                  end else begin
                     line++;
                  end
               end
               default: begin
                  // printable bytes past the width are dropped
                  if (col < nc) begin
                     y = (line > nr - 1) ? nr - 1 : line;
                     base = y * SCR_COLS;
                     code = mono_glyph(it.char_code);
                     if (insert_on) begin
                        for (int i = nc - 1; i > col; i--)
                           glyphs[base + i] = glyphs[base + i - 1];
                        inserts++;
                     end
                     glyphs[base + col] = {attr_reg, code};
                     col++;
                  end
               end
            endcase
         end
         r.cursor_col = 8'(col);
         r.cursor_row = 6'(line);
         cursor_reports.push_back(r);
      endfunction

      function void mismatch(string field, logic [15:0] want_v, logic [15:0] got_v);
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field, want_v, got_v);
         errors++;
      endfunction

      // compare one result with the oldest outstanding report
      function void match_report(rsp_type got);
         rsp_type want;
         if (cursor_reports.size() == 0) begin
            $display("%0t: result with nothing outstanding, expected none, actual 0x%0h",
                     $time, got);
            errors++;
            return;
         end
         want = cursor_reports.pop_front();
         if (got.cursor_col !== want.cursor_col)
            mismatch("cursor_col", 16'(want.cursor_col), 16'(got.cursor_col));
         if (got.cursor_row !== want.cursor_row)
            mismatch("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
         if (got.cell_char !== want.cell_char)
            mismatch("cell_char", 16'(want.cell_char), 16'(got.cell_char));
         if (got.cell_attr !== want.cell_attr)
            mismatch("cell_attr", want.cell_attr, got.cell_attr);
         if (got.scrolled !== want.scrolled)
            mismatch("scrolled", 16'(want.scrolled), 16'(got.scrolled));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_COLUMNS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   terminal_screen screen;
   int             sent = 0;
   int             setups = 0;

   text_terminal_char_writer u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) screen.match_report(rsp_data);
   end

   // sender gap: busy at first, heavier next, none at the end
   function automatic int idle_gap();
      int pct;
      int gap;
      pct = (sent < 217) ? 29 : ((sent < 434) ? 74 : 0);
      gap = 0;
      while (gap < 40 && $urandom_range(99) < pct) gap++;
      return gap;
   endfunction

   function automatic req_type char_item(input logic [7:0] code);
      req_type it;
      it.kind = 1'b0;
      it.char_code = code;
      it.read_col = 7'($urandom);
      it.read_row = 6'($urandom);
      return it;
   endfunction

   function automatic req_type read_item(input logic [6:0] c, input logic [5:0] r);
      req_type it;
      it.kind = 1'b1;
      it.char_code = 8'($urandom);
      it.read_col = c;
      it.read_row = r;
      return it;
   endfunction

   // random item mix: text, control bytes, reads and newlines, with the newline share set by nl_pct
   function automatic req_type pick_item(input int nl_pct, input int span_c, input int span_r);
      req_type it;
      int      roll;
      it = char_item(8'($urandom));
      roll = $urandom_range(99);
      if (roll < 15) begin
         it.kind = 1'b1;
         if ($urandom_range(1)) begin
            it.read_col = 7'($urandom_range(span_c - 1));
            it.read_row = 6'($urandom_range(span_r - 1));
         end
      end else if (roll < 15 + nl_pct * 85 / 100) begin
         it.char_code = CHR_NL;
      end else begin
         roll = $urandom_range(99);
         if (roll < 6) it.char_code = CHR_CR;
         else if (roll < 13) it.char_code = CHR_TAB;
         else if (roll < 20) it.char_code = CHR_BS;
         else if (roll < 40) it.char_code = 8'($urandom_range(8'hDF, 8'hB0));
         else if (roll < 85) it.char_code = 8'($urandom_range(8'h7E, 8'h20));
      end
      return it;
   endfunction

   // one input transfer, optionally after an idle gap
   task automatic push(input req_type it, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      screen.apply_item(it);
      sent++;
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (screen.outstanding() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one register transfer; valid is lowered by the caller
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      screen.set_reg(idx, val);
   endtask

   task automatic apply_setup(input int cols, input int rows, input logic [15:0] attr,
                              input bit ins, input bit color);
      write_reg(CSR_COLUMNS, 16'(cols));
      write_reg(CSR_ROWS, 16'(rows));
      write_reg(CSR_ATTRIBUTE, attr);
      write_reg(CSR_INSERT_MODE, 16'(ins));
      write_reg(CSR_COLOR_DISPLAY, 16'(color));
      csr_valid <= 1'b0;
      setups++;
   endtask

   // random items under one register setting
   task automatic run_phase(input int cols, input int rows, input logic [15:0] attr,
                            input bit ins, input bit color, input int count,
                            input int nl_pct);
      drain();
      apply_setup(cols, rows, attr, ins, color);
      for (int k = 0; k < count; k++) begin
         push(pick_item(nl_pct, screen.cols_in_use(), screen.rows_in_use()), idle_gap());
         // occasional full pause with nothing in flight
         if (sent % 97 == 0) drain();
      end
   endtask

   // edge cases: reset values, mono mapping, tabs, backspace at 0, drops, scrolls, clamps
   task automatic run_directed();
      logic [7:0] seq_bytes [$];
      push(read_item(7'd0, 6'd0), idle_gap());
      push(char_item(8'h48), idle_gap());
      push(char_item(CHR_HLINE_S), idle_gap());
      drain();
      apply_setup(16, 3, 16'hFFFF, 1'b0, 1'b0);
      seq_bytes = '{CHR_VLINE_S, CHR_VLINE_D, CHR_HLINE_S, CHR_HLINE_D, CHR_SHADE_LO,
                    CHR_SHADE_HI, 8'hC5, CHR_MONO_BELOW, CHR_MONO_ABOVE, 8'hFF,
                    CHR_BS, CHR_CR, CHR_BS, CHR_TAB, CHR_TAB, CHR_TAB, 8'h78,
                    CHR_NL, CHR_NL, CHR_NL, CHR_NL};
      foreach (seq_bytes[i]) push(char_item(seq_bytes[i]), idle_gap());
      push(read_item(7'h7F, 6'h3F), idle_gap());
      push(read_item(7'd0, 6'd0), idle_gap());
   endtask

   // main sequence
   initial begin
      screen = new;
      screen.reset_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // store clear after reset
      @(posedge clock);
      while (busy) @(posedge clock);

      run_directed();
      run_phase(16, 3, 16'($urandom), 1'b0, 1'b0, 80, 8);
      run_phase(16, 3, 16'($urandom), 1'b1, 1'b1, 70, 8);
      run_phase(0, 0, 16'h0000, 1'b0, 1'b1, 40, 10);
      run_phase(1, 1, 16'($urandom), 1'b1, 1'b0, 40, 10);
      run_phase(128, 4, 16'hFFFF, 1'b1, 1'b0, 70, 6);
      run_phase(255, 2, 16'($urandom), 1'b0, 1'b1, 50, 8);
      run_phase(40, 64, 16'($urandom), 1'b0, 1'b1, 50, 15);
      // cursor row now likely below the last row in use
      run_phase(24, 5, 16'($urandom), 1'b1, 1'b0, 60, 8);
      run_phase(128, 127, 16'($urandom), 1'b0, 1'b1, 90, 75);
      run_phase(80, 25, 16'd7, 1'b0, 1'b1, 80, 3);

      drain();
      repeat (16) @(posedge clock);
      $display("covered %0d items: %0d cell reads, %0d scrolls, %0d insert writes",
               screen.items, screen.reads, screen.scrolls, screen.inserts);
      $display("%0d register settings applied, %0d mismatches", setups, screen.errors);
      if (screen.errors == 0 && screen.outstanding() == 0) begin
         $display("text_terminal_char_writer regression: pass");
      end else begin
         $display("text_terminal_char_writer regression: fail");
      end
      $finish;
   end

   // watchdog, well above every item being a full-height scroll
   initial begin
      #500000000;
      $display("%0t: run timed out", $time);
      $display("text_terminal_char_writer regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
src/ttcw_pkg.sv
src/ttcw_ram.sv
src/ttcw_ctrl.sv
src/ttcw_datapath.sv
src/text_terminal_char_writer.sv
sim/tb.sv
